// ===== design/swa_pkg.sv =====
// swa_pkg: shared constants for the sliding window average block.
// No dependencies; compiled first.
package swa_pkg;

  localparam int CFG_W     = 9;   // window size register width
  localparam int OUT_W     = 24;  // width of both result fields
  localparam int FRAC_BITS = 8;   // fraction bits of the average

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

endpackage

// ===== design/swa_if.sv =====
// swa_in_if / swa_out_if: valid/ready request channels of the block.
// Depends on swa_pkg for the result field width.
interface swa_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swa_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [swa_pkg::OUT_W-1:0] average_q8;
  logic signed [swa_pkg::OUT_W-1:0] window_sum;

  modport source (output valid, output average_q8, output window_sum, input ready);
  modport sink   (input valid, input average_q8, input window_sum, output ready);
endinterface

// ===== design/swa_front.sv =====
// swa_front: takes samples, keeps the history memory, running sum and fill count.
// Hands window sums and window sizes on to the queue. Depends on swa_pkg.
module swa_front #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int KW          = $clog2(MAX_WINDOW + 1),
  parameter int SUMW        = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          in_restart_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic signed [SUMW-1:0]        push_sum_o,
  output logic [KW-1:0]                 push_k_o
);

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AW = KW + 1;

  typedef enum logic [1:0] {
    ST_TAKE   = 2'b01,
    ST_UPDATE = 2'b10
  } front_state_e;

  front_state_e               state_q, state_d;
  logic [swa_pkg::CFG_W-1:0]  ws_q;
  logic [PW-1:0]              wp_q;
  logic [KW-1:0]              fill_q;
  logic signed [SUMW-1:0]     sum_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

  logic [KW-1:0]              k;
  logic                       take, commit, full, need_push;
  logic [PW-1:0]              wp_eff, rd_addr;
  logic [AW-1:0]              addr_tmp;
  logic signed [SAMPLE_BITS-1:0] sub;
  logic signed [SUMW:0]       sum_next;

  always_comb begin
    if (ws_q == '0) begin
      k = KW'(1);
    end else if (32'(ws_q) > MAX_WINDOW) begin
      k = KW'(MAX_WINDOW);
    end else begin
      k = KW'(ws_q);
    end
  end

  assign in_ready_o = (state_q == ST_TAKE);
  assign take       = in_valid_i && in_ready_o;

  // oldest entry of the window, after a restart has cleared the pointer
  assign wp_eff   = in_restart_i ? '0 : wp_q;
  assign addr_tmp = AW'(wp_eff) + AW'(MAX_WINDOW) - AW'(k);
  assign rd_addr  = (addr_tmp >= AW'(MAX_WINDOW)) ? PW'(addr_tmp - AW'(MAX_WINDOW))
                                                  : PW'(addr_tmp);

  assign full      = (fill_q >= k);
  assign need_push = ((AW'(fill_q) + AW'(1)) >= AW'(k));
  assign sub       = full ? old_q : '0;
  assign sum_next  = (SUMW+1)'(sum_q) + (SUMW+1)'(x_q) - (SUMW+1)'(sub);
  assign commit    = (state_q == ST_UPDATE) && (!need_push || push_ready_i);

  assign push_valid_o = (state_q == ST_UPDATE) && need_push;
  assign push_sum_o   = SUMW'(sum_next);
  assign push_k_o     = k;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_TAKE:   if (take) state_d = ST_UPDATE;
      ST_UPDATE: if (commit) state_d = ST_TAKE;
      default:   state_d = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      ws_q    <= swa_pkg::CFG_W'(1);
      wp_q    <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ws_q   <= cfg_wdata_i;
        wp_q   <= '0;
        fill_q <= '0;
        sum_q  <= '0;
      end else if (take && in_restart_i) begin
        wp_q   <= '0;
        fill_q <= '0;
        sum_q  <= '0;
      end else if (commit) begin
        wp_q  <= (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + PW'(1);
        sum_q <= SUMW'(sum_next);
        if (!full) fill_q <= fill_q + KW'(1);
      end
    end
  end

  // history memory: one read on accept, one write on commit
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q   <= in_sample_i;
      old_q <= hist_mem[rd_addr];
    end
    if (commit) hist_mem[wp_q] <= x_q;
  end

endmodule

// ===== design/swa_queue.sv =====
// swa_queue: short FIFO between the front and the back part.
// No package dependency.
module swa_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
      if (pop)  rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= push_data_i;
  end

endmodule

// ===== design/swa_back.sv =====
// swa_back: bit-serial divider for sum*256/k, saturation and output register.
// Depends on swa_pkg for output width and limits.
module swa_back #(
  parameter int KW   = 9,
  parameter int SUMW = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pop_valid_i,
  output logic                             pop_ready_o,
  input  logic signed [SUMW-1:0]           pop_sum_i,
  input  logic [KW-1:0]                    pop_k_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [swa_pkg::OUT_W-1:0] out_average_q8_o,
  output logic signed [swa_pkg::OUT_W-1:0] out_window_sum_o
);

  localparam int NW  = SUMW + swa_pkg::FRAC_BITS;
  localparam int CNW = $clog2(NW + 1);
  localparam int QCW = ((NW + 1 > swa_pkg::OUT_W) ? NW + 1 : swa_pkg::OUT_W) + 1;
  localparam int SCW = ((SUMW > swa_pkg::OUT_W) ? SUMW : swa_pkg::OUT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_e;

  back_state_e            state_q;
  logic signed [SUMW-1:0] sum_q;
  logic [KW-1:0]          k_q;
  logic                   neg_q;
  logic [NW-1:0]          num_q;
  logic [KW:0]            rem_q;
  logic [CNW-1:0]         cnt_q;
  logic                   out_valid_q;
  logic signed [swa_pkg::OUT_W-1:0] avg_q, wsum_q;

  logic                   pop, load;
  logic [SUMW-1:0]        mag;
  logic [KW:0]            rem_sh;
  logic                   q_bit;
  logic signed [QCW-1:0]  quot_s;
  logic signed [SCW-1:0]  sum_s;
  logic signed [swa_pkg::OUT_W-1:0] avg_sat, sum_sat;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign load        = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign mag         = pop_sum_i[SUMW-1] ? SUMW'(-pop_sum_i) : SUMW'(pop_sum_i);

  // one restoring step: remainder stays below k, so KW+1 bits hold the shift
  assign rem_sh = {rem_q[KW-1:0], num_q[NW-1]};
  assign q_bit  = (rem_sh >= (KW+1)'(k_q));

  assign quot_s = neg_q ? -QCW'({1'b0, num_q}) : QCW'({1'b0, num_q});
  assign sum_s  = SCW'(sum_q);

  always_comb begin
    if (quot_s > QCW'(swa_pkg::OUT_MAX)) begin
      avg_sat = swa_pkg::OUT_W'(swa_pkg::OUT_MAX);
    end else if (quot_s < QCW'(swa_pkg::OUT_MIN)) begin
      avg_sat = swa_pkg::OUT_W'(swa_pkg::OUT_MIN);
    end else begin
      avg_sat = swa_pkg::OUT_W'(quot_s);
    end
    if (sum_s > SCW'(swa_pkg::OUT_MAX)) begin
      sum_sat = swa_pkg::OUT_W'(swa_pkg::OUT_MAX);
    end else if (sum_s < SCW'(swa_pkg::OUT_MIN)) begin
      sum_sat = swa_pkg::OUT_W'(swa_pkg::OUT_MIN);
    end else begin
      sum_sat = swa_pkg::OUT_W'(sum_s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (pop) begin
          cnt_q   <= CNW'(NW);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNW'(1);
          if (cnt_q == CNW'(1)) state_q <= ST_DONE;
        end
        ST_DONE: if (load) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sum_q <= pop_sum_i;
      k_q   <= pop_k_i;
      neg_q <= pop_sum_i[SUMW-1];
      num_q <= {mag, {swa_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= q_bit ? rem_sh - (KW+1)'(k_q) : rem_sh;
      num_q <= {num_q[NW-2:0], q_bit};
    end
    if (load) begin
      avg_q  <= avg_sat;
      wsum_q <= sum_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_average_q8_o = avg_q;
  assign out_window_sum_o = wsum_q;

endmodule

// ===== design/sliding_window_average.sv =====
// sliding_window_average: boxcar moving average over the last window_size samples.
// Depends on swa_pkg, swa_if, swa_front, swa_queue and swa_back.
//
//  channel   | dir | handshake         | contents
//  ----------+-----+-------------------+---------------------------------------
//  sample_i  | in  | valid/ready       | sample (signed), restart
//  result_o  | out | valid/ready       | average_q8 (signed Q.8), window_sum
//  cfg       | in  | cfg_we_i, no wait | window_size (9 bits, reset 1)
//
// A sample is taken in ST_TAKE (memory read of the oldest entry), then ST_UPDATE
// does the sum update and write-back; the front takes no new sample until it commits.
// Each result then runs in the bit-serial divider, which takes no new sum until
// its result has moved to the output register; the divider sets the sustained rate
// once the window is full, and the two-entry queue absorbs short bursts ahead of it.
// Reset clears window state and sets window_size to 1; history needs no clear.
// A stalled result waits in the output register; the divider may finish one more
// result and holds it in ST_DONE, and the front stalls only when the queue is full.
module sliding_window_average #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0]     cfg_wdata_i,
  swa_in_if.sink                        sample_i,
  swa_out_if.source                     result_o
);

  localparam int KW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int QW   = SUMW + KW;

  logic                   push_valid, push_ready, pop_valid, pop_ready;
  logic signed [SUMW-1:0] push_sum;
  logic [KW-1:0]          push_k;
  logic [QW-1:0]          pop_data;

  // front: history, running sum and fill count; one request out per result
  swa_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .KW          (KW),
    .SUMW        (SUMW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (sample_i.valid),
    .in_ready_o   (sample_i.ready),
    .in_sample_i  (SAMPLE_BITS'(sample_i.sample)),
    .in_restart_i (sample_i.restart),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_sum_o   (push_sum),
    .push_k_o     (push_k)
  );

  // window size travels with the sum so the divider never looks back
  swa_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_k, push_sum}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  swa_back #(
    .KW   (KW),
    .SUMW (SUMW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_sum_i        (signed'(pop_data[SUMW-1:0])),
    .pop_k_i          (pop_data[QW-1:SUMW]),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .out_average_q8_o (result_o.average_q8),
    .out_window_sum_o (result_o.window_sum)
  );

endmodule

// ===== design/swa_checker.sv =====
// swa_checker: port-level assertions for sliding_window_average, bound below.
// Depends on swa_pkg for the result width.
module swa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [swa_pkg::OUT_W-1:0] out_average_q8_i,
  input logic signed [swa_pkg::OUT_W-1:0] out_window_sum_i
);

  logic [15:0] pending_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests taken minus results delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= (pending_q == '1) ? pending_q : pending_q + 16'd1;
    end else if (out_acc && !in_acc && pending_q != '0) begin
      pending_q <= pending_q - 16'd1;
    end
  end

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_average_q8_i) && $stable(out_window_sum_i))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != '0)
    else $error("result without an earlier request");

  a_sign_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_average_q8_i[swa_pkg::OUT_W-1] == out_window_sum_i[swa_pkg::OUT_W-1])
                    && ((out_average_q8_i == '0) == (out_window_sum_i == '0)))
    else $error("average and sum disagree in sign");

endmodule

bind sliding_window_average swa_checker u_swa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (sample_i.valid),
  .in_ready_i       (sample_i.ready),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .out_average_q8_i (result_o.average_q8),
  .out_window_sum_i (result_o.window_sum)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for sliding_window_average, boxcar sum and Q.8 average.
// Depends on swa_pkg, swa_in_if / swa_out_if and the sliding_window_average RTL.
module tb;

  localparam int HIST_DEPTH    = 256;   // MAX_WINDOW of the instance
  localparam int SMP_W         = 16;    // SAMPLE_BITS of the instance
  localparam int SETTLE_CYCLES = 96;    // front + divider + queue, with margin
  localparam int STALL_LIMIT   = 4000;  // cycles without any accepted request
  localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    restart;
  } sample_req_t;

  typedef struct packed {
    logic signed [swa_pkg::OUT_W-1:0] average_q8;
    logic signed [swa_pkg::OUT_W-1:0] window_sum;
  } window_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [swa_pkg::CFG_W-1:0] cfg_wdata_i;

  swa_in_if #(.SAMPLE_BITS(SMP_W)) smp_if ();
  swa_out_if                       res_if ();

  sliding_window_average #(
    .MAX_WINDOW (HIST_DEPTH),
    .SAMPLE_BITS(SMP_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (smp_if.sink),
    .result_o   (res_if.source)
  );

  // Requests waiting to be offered, and results owed by the block.
  sample_req_t    pending_reqs[$];
  window_result_t averages_due[$];

  // Idle odds in percent; set per phase by the stimulus.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        long_hold_req = 1'b0;
  int          error_count   = 0;

  // Shadow of the filter: window register, circular history, running sum.
  logic [swa_pkg::CFG_W-1:0] window_reg = 1;
  logic signed [SMP_W-1:0]   hist [HIST_DEPTH];
  longint                    run_sum    = 0;
  int unsigned               fill_cnt   = 0;
  logic [7:0]                wr_ptr     = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [swa_pkg::OUT_W-1:0] clamp_out(input longint v);
    if (v > longint'(swa_pkg::OUT_MAX)) return swa_pkg::OUT_W'(swa_pkg::OUT_MAX);
    if (v < longint'(swa_pkg::OUT_MIN)) return swa_pkg::OUT_W'(swa_pkg::OUT_MIN);
    return swa_pkg::OUT_W'(v);
  endfunction

  // Zero is taken as one, anything above the history depth as the full depth.
  function automatic int unsigned span_of(input logic [swa_pkg::CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > HIST_DEPTH) return HIST_DEPTH;
    return w;
  endfunction

  function automatic void clear_window();
    run_sum  = 0;
    fill_cnt = 0;
    wr_ptr   = 0;
  endfunction

  // Takes one sample into the shadow window; owes a result once it is full.
  function automatic void predict_average(input logic signed [SMP_W-1:0] x,
                                          input logic restart);
    int unsigned    k;
    logic [7:0]     oldest;
    window_result_t res;
    k = span_of(window_reg);
    if (restart) clear_window();
    if (fill_cnt >= k) begin
      oldest  = wr_ptr - 8'(k);   // k of the full depth lands on wr_ptr itself
      run_sum = run_sum - longint'(hist[oldest]);
    end else begin
      fill_cnt++;
    end
    run_sum      = run_sum + longint'(x);
    hist[wr_ptr] = x;
    wr_ptr       = wr_ptr + 8'd1;
    if (fill_cnt < k) return;
    res.average_q8 = clamp_out((run_sum * 256) / longint'(k));  // truncates toward zero
    res.window_sum = clamp_out(run_sum);
    averages_due.push_back(res);
  endfunction

  // Request driver: holds valid until accepted, then takes the next request
  // or idles at the current odds.
  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    sample_req_t nxt;
    if (!rst_ni) begin
      smp_if.valid   <= 1'b0;
      smp_if.sample  <= '0;
      smp_if.restart <= 1'b0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        predict_average(smp_if.sample, smp_if.restart);
      end
      if (!smp_if.valid || smp_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          smp_if.valid   <= 1'b1;
          smp_if.sample  <= nxt.sample;
          smp_if.restart <= nxt.restart;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares against the oldest owed result, and drives
  // ready, including one long hold-off so the queue fills and the front stalls.
  int   hold_left;
  logic hold_taken;

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    window_result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (averages_due.size() == 0) begin
          $error("unexpected result: average_q8 %0d window_sum %0d",
                 res_if.average_q8, res_if.window_sum);
          error_count++;
        end else begin
          want = averages_due.pop_front();
          if (res_if.average_q8 !== want.average_q8) begin
            $error("average_q8: expected %0d, got %0d", want.average_q8, res_if.average_q8);
            error_count++;
          end
          if (res_if.window_sum !== want.window_sum) begin
            $error("window_sum: expected %0d, got %0d", want.window_sum, res_if.window_sum);
            error_count++;
          end
        end
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken   <= 1'b1;
        hold_left    <= LONG_HOLD;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any cycle with an accepted request on either side restarts it.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic signed [SMP_W-1:0] s, input logic r);
    sample_req_t q;
    q.sample  = s;
    q.restart = r;
    pending_reqs.push_back(q);
  endtask

  // Sender pause: nothing offered, nothing owed, then room for a sample that
  // owes no result to leave the pipeline.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || smp_if.valid || averages_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only with the block idle; it also clears the window.
  task automatic write_window(input logic [swa_pkg::CFG_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    window_reg   = value;
    clear_window();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Three idling regimes in turn: slow receiver, slow sender, neither.
  task automatic set_idling(input int unsigned regime);
    case (regime % 3)
      0: begin
        send_idle_pct = 31;
        recv_idle_pct = 81;
      end
      1: begin
        send_idle_pct = 81;
        recv_idle_pct = 31;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Mostly random words, with the rails now and then.
  function automatic logic signed [SMP_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 16'sh7FFF;
    if (r < 10) return 16'sh8000;
    return SMP_W'($urandom());
  endfunction

  task automatic random_phase(input logic [swa_pkg::CFG_W-1:0] w, input int n,
                              input int unsigned restart_odds);
    write_window(w);
    for (int i = 0; i < n; i++)
      queue_req(pick_sample(), $urandom_range(restart_odds - 1) == 0);
  endtask

  logic [swa_pkg::CFG_W-1:0] small_wins [8] =
    '{9'd2, 9'd7, 9'd0, 9'd16, 9'd3, 9'd1, 9'd40, 9'd5};

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset window of one, rails, restart with a one-sample window.
    set_idling(0);
    queue_req(16'sh7FFF, 1'b0);
    queue_req(16'sh8000, 1'b0);
    queue_req(16'sh0000, 1'b0);
    queue_req(-16'sd1,   1'b1);
    queue_req(16'sh0001, 1'b0);
    queue_req(16'sh5555, 1'b0);
    queue_req(16'shAAAA, 1'b0);
    // Window of three: negative rail, restart mid-stream, truncation of -512/3.
    write_window(9'd3);
    queue_req(16'sh8000, 1'b0);
    queue_req(16'sh8000, 1'b0);
    queue_req(16'sh8000, 1'b0);
    queue_req(16'sh7FFF, 1'b1);
    queue_req(16'sh7FFF, 1'b0);
    queue_req(16'sh7FFF, 1'b0);
    queue_req(16'sh8000, 1'b0);
    queue_req(-16'sd1,   1'b0);
    // Zero written: behaves as a window of one.
    write_window(9'd0);
    queue_req(16'sd5,  1'b0);
    queue_req(-16'sd5, 1'b0);
    queue_req(16'sd0,  1'b1);
    // Two-sample window, restart on the second request.
    write_window(9'd2);
    queue_req(-16'sd1, 1'b0);
    queue_req(-16'sd1, 1'b1);
    queue_req(-16'sd3, 1'b0);

    // Over-range register value saturates to the full depth: drive the sum
    // to both rails.
    set_idling(0);
    write_window(9'd511);
    for (int i = 0; i < HIST_DEPTH; i++) queue_req(16'sh8000, 1'b0);
    for (int i = 0; i < HIST_DEPTH; i++) queue_req(16'sh7FFF, 1'b0);

    // Random phases, small windows mostly: slow sender, then no idling.
    for (int p = 0; p < 8; p++) begin
      set_idling((p < 4) ? 1 : 2);
      random_phase(small_wins[p], 80, 25);
    end
    set_idling(2);
    random_phase(9'd100, 250, 1000);
    set_idling(2);
    random_phase(9'd256, 350, 1000);

    // Back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering one-sample windows.
    set_idling(2);
    write_window(9'd1);
    long_hold_req = 1'b1;
    for (int i = 0; i < 100; i++) queue_req(pick_sample(), $urandom_range(3) == 0);

    wait_drained();
    if (error_count == 0 && averages_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
